@@ rtl/seqi_pkg.sv @@
// package for the sorted event queue insert core
// request/result payload types, stored entry type and cell link type; no dependencies
`timescale 1ns / 1ps

package seqi_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		STATUS_INSERTED = 2'd0,
		STATUS_ZERO_PID = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		logic        event_type;
		logic [31:0] event_time;
		logic [31:0] process_id;
	} seqi_in_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  insert_position;
		logic [4:0]  entry_count;
		logic [31:0] head_time;
		logic        head_type;
		logic [31:0] head_pid;
	} seqi_out_t;

	typedef struct packed {
		logic [31:0] ev_time;
		logic        ev_kind;
		logic [31:0] ev_pid;
	} entry_t;

	// what a cell hands to its right neighbor
	typedef struct packed {
		entry_t entry;
		logic   valid;
		logic   take;
	} link_t;

endpackage

@@ rtl/seqi_cell.sv @@
// one slot of the sorted queue: holds an entry, compares it with the new request
// and either keeps it, takes the left neighbor's entry, or takes the new one; uses seqi_pkg
`timescale 1ns / 1ps

module seqi_cell
	import seqi_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ins_en,
	input  entry_t new_entry,
	input  link_t  left,
	output link_t  right,
	output entry_t nxt_entry
);

	entry_t entry_q;
	logic   valid_q;
	logic   gt;
	logic   take;
	logic   nxt_valid;

	// stored entry sorts strictly after the new one
	always_comb begin
		if (entry_q.ev_time != new_entry.ev_time) begin
			gt = entry_q.ev_time > new_entry.ev_time;
		end else begin
			gt = new_entry.ev_kind & ~entry_q.ev_kind;
		end
	end

	// monotone along the chain: empty slots sit behind all filled ones
	assign take  = ~valid_q | gt;
	assign right = '{entry: entry_q, valid: valid_q, take: take};

	always_comb begin
		priority if (left.take) begin
			nxt_entry = left.entry;
			nxt_valid = left.valid;
		end else if (take) begin
			nxt_entry = new_entry;
			nxt_valid = 1'b1;
		end else begin
			nxt_entry = entry_q;
			nxt_valid = valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_en) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			entry_q <= nxt_entry;
		end
	end

endmodule

@@ rtl/sorted_event_queue_insert_core.sv @@
// top level of the sorted event queue insert core: row of seqi_cell slots,
// fill count, status logic and result register; uses seqi_pkg and seqi_cell
//
//  channel | valid     | ready     | payload           | direction
//  req     | req_valid | req_ready | req (seqi_in_t)   | into the core
//  rsp     | rsp_valid | rsp_ready | rsp (seqi_out_t)  | out of the core
//
// one request per cycle while req_ready is high: all cells compare against
// the new event at once and shift or load in the same cycle, the result
// lands in the output register in the cycle after its request is accepted.
// reset empties the queue (valid bits and count cleared) and drops any result.
// req_ready is low only while a result waits and rsp_ready is low.
`timescale 1ns / 1ps

module sorted_event_queue_insert_core
	import seqi_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  seqi_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output seqi_out_t rsp
);

	localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             req_fire;
	logic             ins_en;
	status_t          status;
	entry_t           new_entry;
	link_t            link [QUEUE_DEPTH+1];
	entry_t           head_nxt [QUEUE_DEPTH];
	logic [IDX_W-1:0] pos;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [IDX_W+3:0] pos_ext;
	logic [CNT_W+4:0] count_ext;
	logic             rsp_valid_q;
	seqi_out_t        rsp_q;
	seqi_out_t        rsp_nxt;

	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign req_fire  = req_valid & req_ready;

	always_comb begin
		priority if (req.process_id == 32'd0) begin
			status = STATUS_ZERO_PID;
		end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
			status = STATUS_FULL;
		end else begin
			status = STATUS_INSERTED;
		end
	end

	assign ins_en    = req_fire & (status == STATUS_INSERTED);
	assign new_entry = '{ev_time: req.event_time, ev_kind: req.event_type,
		ev_pid: req.process_id};

	assign link[0] = '{entry: '0, valid: 1'b0, take: 1'b0};

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		seqi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins_en    (ins_en),
			.new_entry (new_entry),
			.left      (link[g]),
			.right     (link[g+1]),
			.nxt_entry (head_nxt[g])
		);
	end

	// insert position: the first cell that takes the new entry
	always_comb begin
		pos = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (link[i+1].take && !link[i].take) begin
				pos = pos | IDX_W'(i);
			end
		end
		if (status != STATUS_INSERTED) begin
			pos = '0;
		end
	end

	assign count_nxt = (status == STATUS_INSERTED) ? count_q + CNT_W'(1) : count_q;
	assign pos_ext   = {4'd0, pos};
	assign count_ext = {5'd0, count_nxt};

	always_comb begin
		rsp_nxt.status          = status;
		rsp_nxt.insert_position = pos_ext[3:0];
		rsp_nxt.entry_count     = count_ext[4:0];
		if (count_nxt == '0) begin
			rsp_nxt.head_time = '0;
			rsp_nxt.head_type = 1'b0;
			rsp_nxt.head_pid  = '0;
		end else if (ins_en) begin
			rsp_nxt.head_time = head_nxt[0].ev_time;
			rsp_nxt.head_type = head_nxt[0].ev_kind;
			rsp_nxt.head_pid  = head_nxt[0].ev_pid;
		end else begin
			// no shift this cycle, cell 0 holds its entry
			rsp_nxt.head_time = link[1].entry.ev_time;
			rsp_nxt.head_type = link[1].entry.ev_kind;
			rsp_nxt.head_pid  = link[1].entry.ev_pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				count_q <= count_nxt;
			end
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
